// ===== rtl/alm_pkg.sv =====
// ----------------------------------------------------------------------------
// alm_pkg
// shared types and constants for the two-tap audio level meter
// ----------------------------------------------------------------------------
`default_nettype none

package alm_pkg;

    localparam int NUM_TAPS = 2;
    localparam int TAP_W    = 1;
    localparam int MAG_W    = 31;
    localparam logic [30:0] MAG_MAX = 31'h7fffffff;
    localparam logic [9:0]  PER_MILLE = 10'd1000;
    localparam logic [7:0]  QVAL_SAT  = 8'd31;

    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_REPORT = 1'b1;

    // one item as it travels through the queue
    typedef struct packed {
        logic        action;
        logic        tap;
        logic [31:0] sample;
        logic        wide_format;
        logic        frame_start;
        logic [15:0] frame_bytes;
        logic [31:0] fmt_generation;
        logic        active_flag;
        logic [7:0]  qval;
    } item_t;

    // handshake between the accumulator and the report divider
    typedef struct packed {
        logic        tap;
        logic [31:0] frames;
        logic [31:0] bytes;
        logic [31:0] cnt;
        logic [30:0] peak;
        logic [63:0] sum;
        logic [30:0] fs;
        logic        changed;
    } rpt_req_t;

    typedef struct packed {
        logic        report_tap;
        logic [31:0] frame_count;
        logic [31:0] byte_count;
        logic [31:0] sampled_count;
        logic [30:0] peak_level;
        logic [30:0] mean_level;
        logic [31:0] peak_per_mille;
        logic [31:0] mean_per_mille;
        logic        status_changed;
    } result_t;

    function automatic logic [30:0] magnitude(logic [31:0] raw, logic wide);
        logic [31:0] m;
        if (wide)
            m = raw[31] ? (32'd0 - raw) : raw;
        else
            m = raw[15] ? {16'd0, 16'd0 - raw[15:0]} : {16'd0, raw[15:0]};
        if (m > {1'b0, MAG_MAX})
            m = {1'b0, MAG_MAX};
        return m[30:0];
    endfunction

    function automatic logic [30:0] scale_for(logic [7:0] q);
        logic [31:0] one_sh;
        if (q == 8'd0 || q >= QVAL_SAT)
            return MAG_MAX;
        one_sh = 32'd1 << q[4:0];
        return one_sh[30:0] - 31'd1;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/alm_front.sv =====
// ----------------------------------------------------------------------------
// alm_front
// input stage and two-entry queue towards the accumulator
// ----------------------------------------------------------------------------
`default_nettype none

module alm_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire alm_pkg::item_t in_item,
    output logic               q_valid,
    input  wire logic          q_ready,
    output alm_pkg::item_t     q_item
);
    import alm_pkg::*;

    item_t      mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign in_ready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign push     = in_valid && in_ready;
    assign pop      = q_valid && q_ready;
    assign q_item   = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> !push) else $error("queue overflow");
    a_count_ok: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3) else $error("queue count out of range");
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> cnt_reg != 2'd0) else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== rtl/alm_accum.sv =====
// ----------------------------------------------------------------------------
// alm_accum
// per-tap statistics; hands reports to the divider
// ----------------------------------------------------------------------------
`default_nettype none

module alm_accum (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [7:0]       decimation,
    input  wire logic             q_valid,
    output logic                  q_ready,
    input  wire alm_pkg::item_t   q_item,
    output logic                  req_valid,
    input  wire logic             req_ready,
    output alm_pkg::rpt_req_t     req
);
    import alm_pkg::*;

    logic [31:0] frames_reg  [NUM_TAPS];
    logic [31:0] bytes_reg   [NUM_TAPS];
    logic [31:0] sampled_reg [NUM_TAPS];
    logic [30:0] peak_reg    [NUM_TAPS];
    logic [63:0] sum_reg     [NUM_TAPS];
    logic [31:0] gen_reg     [NUM_TAPS];
    logic        act_reg     [NUM_TAPS];
    logic [7:0]  phase_reg   [NUM_TAPS];

    logic        req_valid_reg;
    rpt_req_t    req_reg;

    logic        t;
    logic        take;
    logic [7:0]  dec, ph, ph_inc;
    logic [30:0] mag;
    logic        changed;
    logic        emit;

    assign t       = q_item.tap;
    // a report may only go when the output slot is free
    assign q_ready = (q_item.action == ACT_SAMPLE) || !req_valid_reg || req_ready;
    assign take    = q_valid && q_ready;
    assign dec     = (decimation == 8'd0) ? 8'd1 : decimation;
    assign ph      = q_item.frame_start ? 8'd0 : phase_reg[t];
    assign ph_inc  = ph + 8'd1;
    assign mag     = magnitude(q_item.sample, q_item.wide_format);
    assign changed = (gen_reg[t] != q_item.fmt_generation)
                  || (act_reg[t] != q_item.active_flag);
    assign emit    = (frames_reg[t] != 32'd0) || changed;

    assign req_valid = req_valid_reg;
    assign req       = req_reg;

    always_ff @(posedge clk)
    begin
        if (take && q_item.action == ACT_REPORT && emit)
        begin
            req_reg.tap     <= t;
            req_reg.frames  <= frames_reg[t];
            req_reg.bytes   <= bytes_reg[t];
            req_reg.cnt     <= sampled_reg[t];
            req_reg.peak    <= peak_reg[t];
            req_reg.sum     <= sum_reg[t];
            req_reg.fs      <= scale_for(q_item.qval);
            req_reg.changed <= changed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_TAPS; i++)
            begin
                frames_reg[i]  <= '0;
                bytes_reg[i]   <= '0;
                sampled_reg[i] <= '0;
                peak_reg[i]    <= '0;
                sum_reg[i]     <= '0;
                gen_reg[i]     <= '0;
                act_reg[i]     <= 1'b0;
                phase_reg[i]   <= '0;
            end
        end
        else
        begin
            if (req_valid_reg && req_ready)
                req_valid_reg <= 1'b0;
            if (take)
            begin
                if (q_item.action == ACT_SAMPLE)
                begin
                    if (q_item.frame_start)
                    begin
                        frames_reg[t] <= frames_reg[t] + 32'd1;
                        bytes_reg[t]  <= bytes_reg[t] + {16'd0, q_item.frame_bytes};
                    end
                    if (ph == 8'd0)
                    begin
                        if (mag > peak_reg[t])
                            peak_reg[t] <= mag;
                        sum_reg[t]     <= sum_reg[t] + {33'd0, mag};
                        sampled_reg[t] <= sampled_reg[t] + 32'd1;
                    end
                    phase_reg[t] <= (ph_inc >= dec) ? 8'd0 : ph_inc;
                end
                else
                begin
                    frames_reg[t]  <= '0;
                    bytes_reg[t]   <= '0;
                    sampled_reg[t] <= '0;
                    peak_reg[t]    <= '0;
                    sum_reg[t]     <= '0;
                    gen_reg[t]     <= q_item.fmt_generation;
                    act_reg[t]     <= q_item.active_flag;
                    if (emit)
                        req_valid_reg <= 1'b1;
                end
            end
        end
    end

    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg && !req_ready |=> req_valid_reg && $stable(req_reg))
        else $error("report request dropped");
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_item.action == ACT_SAMPLE |=> phase_reg[$past(t)] < $past(dec))
        else $error("phase beyond decimation");
    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        take && q_item.action == ACT_REPORT |=> sampled_reg[$past(t)] == 32'd0)
        else $error("report did not clear");

endmodule

`default_nettype wire

// ===== rtl/alm_report.sv =====
// ----------------------------------------------------------------------------
// alm_report
// restoring divider for mean and per-mille figures, one bit a cycle
// ----------------------------------------------------------------------------
`default_nettype none

module alm_report (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_ready,
    input  wire alm_pkg::rpt_req_t req,
    output logic                  res_valid,
    input  wire logic             res_ready,
    output alm_pkg::result_t      res
);
    import alm_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_MEAN = 3'd1;
    localparam logic [2:0] ST_PMP  = 3'd2;
    localparam logic [2:0] ST_PMM  = 3'd3;
    localparam logic [2:0] ST_OUT  = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [6:0]  bit_reg;
    rpt_req_t    r_reg;
    logic [63:0] quo_reg;
    logic [63:0] rem_reg;
    logic [63:0] dvd_reg;
    logic [31:0] dvs_reg;
    logic [30:0] mean_reg;
    logic [31:0] pmp_reg;
    result_t     res_reg;
    logic        res_valid_reg;

    logic [64:0] rem_sh;
    logic        ge;
    logic [63:0] rem_new;
    logic [63:0] quo_new;
    logic [40:0] prod;
    logic        last;
    logic [30:0] mean_sat;

    assign rem_sh  = {rem_reg, dvd_reg[63]};
    assign ge      = rem_sh >= {33'd0, dvs_reg};
    assign rem_new = ge ? (rem_sh[63:0] - {32'd0, dvs_reg}) : rem_sh[63:0];
    assign quo_new = {quo_reg[62:0], ge};
    assign last    = (bit_reg == 7'd0);
    assign mean_sat = (quo_new[63:31] != 33'd0) ? MAG_MAX : quo_new[30:0];

    // peak per-mille dividend: peak times 1000, 41 bits placed at the top of the dividend register
    assign prod = {10'd0, r_reg.peak} * {31'd0, PER_MILLE};

    assign req_ready = (state_reg == ST_IDLE);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (req_valid) state_next = ST_MEAN;
            ST_MEAN: if (last || r_reg.cnt == 32'd0) state_next = ST_PMP;
            ST_PMP:  if (last) state_next = ST_PMM;
            ST_PMM:  if (last) state_next = ST_OUT;
            ST_OUT:  if (!res_valid_reg || res_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                r_reg   <= req;
                dvd_reg <= req.sum;
                dvs_reg <= req.cnt;
                rem_reg <= '0;
                quo_reg <= '0;
                bit_reg <= 7'd63;
            end
            ST_MEAN, ST_PMP, ST_PMM:
            begin
                rem_reg <= rem_new;
                quo_reg <= quo_new;
                dvd_reg <= {dvd_reg[62:0], 1'b0};
                bit_reg <= bit_reg - 7'd1;
                if (state_reg == ST_MEAN && (last || r_reg.cnt == 32'd0))
                begin
                    mean_reg <= (r_reg.cnt == 32'd0) ? 31'd0 : mean_sat;
                    dvd_reg  <= {prod, 23'd0};
                    dvs_reg  <= {1'b0, r_reg.fs};
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    bit_reg  <= 7'd40;
                end
                else if (state_reg == ST_PMP && last)
                begin
                    pmp_reg  <= quo_new[31:0];
                    dvd_reg  <= {{10'd0, mean_reg} * {31'd0, PER_MILLE}, 23'd0};
                    rem_reg  <= '0;
                    quo_reg  <= '0;
                    bit_reg  <= 7'd40;
                end
            end
            ST_OUT:
            begin
                // quo_reg holds the mean per-mille quotient until the slot frees
                if (!res_valid_reg || res_ready)
                begin
                    res_reg.report_tap     <= r_reg.tap;
                    res_reg.frame_count    <= r_reg.frames;
                    res_reg.byte_count     <= r_reg.bytes;
                    res_reg.sampled_count  <= r_reg.cnt;
                    res_reg.peak_level     <= r_reg.peak;
                    res_reg.mean_level     <= mean_reg;
                    res_reg.peak_per_mille <= pmp_reg;
                    res_reg.mean_per_mille <= quo_reg[31:0];
                    res_reg.status_changed <= r_reg.changed;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_valid_reg && res_ready)
                res_valid_reg <= 1'b0;
            if (state_reg == ST_OUT && (!res_valid_reg || res_ready))
                res_valid_reg <= 1'b1;
        end
    end

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && !res_ready |=> res_valid_reg && $stable(res_reg))
        else $error("result changed while stalled");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !req_ready) else $error("ready while busy");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg == ST_MEAN) else $error("divider not started");

endmodule

`default_nettype wire

// ===== rtl/audio_level_meter_two_tap_core.sv =====
// ----------------------------------------------------------------------------
// audio_level_meter_two_tap_core
// peak and mean level meter for a near and a far audio tap
//
//  channel   dir   handshake                 words
//  input     in    in_valid / in_ready       action, tap, sample, ...
//  result    out   out_valid / out_ready     report_tap ... status_changed
//  config    in    decimation_we             decimation
//
//  a sample word is registered in the queue before the accumulators take it, and may wait behind a stalled report
//  a report word passes through the divider before out_valid: 64 mean
//  steps, then 41 + 41 per-mille steps
//  with no samples in the interval the mean takes one step instead of 64
//  a report stalls the queue only while the previous one still waits for the busy divider
//  reset clears all per-tap statistics and sets decimation to one
// ----------------------------------------------------------------------------
`default_nettype none

module audio_level_meter_two_tap_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        decimation_we,
    input  wire logic [7:0]  decimation_wdata,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        action,
    input  wire logic        tap,
    input  wire logic signed [31:0] sample,
    input  wire logic        wide_format,
    input  wire logic        frame_start,
    input  wire logic [15:0] frame_bytes,
    input  wire logic [31:0] fmt_generation,
    input  wire logic        active_flag,
    input  wire logic [7:0]  qval,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             report_tap,
    output logic [31:0]      frame_count,
    output logic [31:0]      byte_count,
    output logic [31:0]      sampled_count,
    output logic [30:0]      peak_level,
    output logic [30:0]      mean_level,
    output logic [31:0]      peak_per_mille,
    output logic [31:0]      mean_per_mille,
    output logic             status_changed
);
    import alm_pkg::*;

    logic [7:0] decimation_reg;
    item_t      in_item, q_item;
    logic       q_valid, q_ready;
    logic       req_valid, req_ready;
    rpt_req_t   req;
    result_t    res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            decimation_reg <= 8'd1;
        else if (decimation_we)
            decimation_reg <= decimation_wdata;
    end

    always_comb
    begin
        in_item.action         = action;
        in_item.tap            = tap;
        in_item.sample         = sample;
        in_item.wide_format    = wide_format;
        in_item.frame_start    = frame_start;
        in_item.frame_bytes    = frame_bytes;
        in_item.fmt_generation = fmt_generation;
        in_item.active_flag    = active_flag;
        in_item.qval           = qval;
    end

    alm_front u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item)
    );

    alm_accum u_accum (
        .clk(clk), .rst_n(rst_n), .decimation(decimation_reg),
        .q_valid(q_valid), .q_ready(q_ready), .q_item(q_item),
        .req_valid(req_valid), .req_ready(req_ready), .req(req)
    );

    alm_report u_report (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req_valid), .req_ready(req_ready), .req(req),
        .res_valid(out_valid), .res_ready(out_ready), .res(res)
    );

    assign report_tap     = res.report_tap;
    assign frame_count    = res.frame_count;
    assign byte_count     = res.byte_count;
    assign sampled_count  = res.sampled_count;
    assign peak_level     = res.peak_level;
    assign mean_level     = res.mean_level;
    assign peak_per_mille = res.peak_per_mille;
    assign mean_per_mille = res.mean_per_mille;
    assign status_changed = res.status_changed;

endmodule

`default_nettype wire

// ===== tb/audio_level_meter_two_tap_core_tb.sv =====
// ----------------------------------------------------------------------------
// audio_level_meter_two_tap_core_tb
// self-checking bench: a behavioural level meter predicts every report word,
// a scoreboard compares each result word in order, both sides idle at random
// ----------------------------------------------------------------------------
`default_nettype none

class level_scoreboard;
    logic [7:0]  decim;
    logic [31:0] frames [2];
    logic [31:0] bytes_q [2];
    logic [31:0] samples [2];
    logic [30:0] peak [2];
    logic [63:0] msum [2];
    logic [31:0] last_gen [2];
    logic        last_act [2];
    logic [7:0]  phase [2];
    alm_pkg::result_t pending [$];
    int errors;

    function void clear_state();
        decim = 8'd1;
        errors = 0;
        for (int t = 0; t < 2; t++)
        begin
            frames[t] = 0; bytes_q[t] = 0; samples[t] = 0; peak[t] = 0;
            msum[t] = 0; last_gen[t] = 0; last_act[t] = 0; phase[t] = 0;
        end
    endfunction

    function logic [63:0] scale_of(logic [7:0] q);
        if (q == 0 || q >= 31)
            return 64'h7fffffff;
        return (64'd1 << q) - 64'd1;
    endfunction

    function logic [63:0] mag_of(logic [31:0] s, logic wide);
        logic [63:0] m;
        if (wide)
            m = s[31] ? (64'h1_0000_0000 - {32'd0, s}) : {32'd0, s};
        else
            m = s[15] ? (64'h1_0000 - {48'd0, s[15:0]}) : {48'd0, s[15:0]};
        if (m > 64'h7fffffff)
            m = 64'h7fffffff;
        return m;
    endfunction

    function void note_input(alm_pkg::item_t it);
        int t;
        logic [7:0] d;
        logic [63:0] m, mean, fs, pm;
        logic chg;
        alm_pkg::result_t r;
        t = it.tap;
        if (it.action == alm_pkg::ACT_SAMPLE)
        begin
            d = (decim == 0) ? 8'd1 : decim;
            if (it.frame_start)
            begin
                frames[t] += 1;
                bytes_q[t] += {16'd0, it.frame_bytes};
                phase[t] = 0;
            end
            if (phase[t] == 0)
            begin
                m = mag_of(it.sample, it.wide_format);
                if (m[30:0] > peak[t])
                    peak[t] = m[30:0];
                msum[t] += m;
                samples[t] += 1;
            end
            phase[t] += 1;
            if (phase[t] >= d)
                phase[t] = 0;
            return;
        end
        chg = (last_gen[t] != it.fmt_generation) || (last_act[t] != it.active_flag);
        fs = scale_of(it.qval);
        mean = 0;
        if (samples[t] != 0)
        begin
            mean = msum[t] / {32'd0, samples[t]};
            if (mean > 64'h7fffffff)
                mean = 64'h7fffffff;
        end
        r.report_tap = it.tap;
        r.frame_count = frames[t];
        r.byte_count = bytes_q[t];
        r.sampled_count = samples[t];
        r.peak_level = peak[t];
        r.mean_level = mean[30:0];
        pm = ({33'd0, peak[t]} * 64'd1000) / fs;
        r.peak_per_mille = pm[31:0];
        pm = (mean * 64'd1000) / fs;
        r.mean_per_mille = pm[31:0];
        r.status_changed = chg;
        if (frames[t] != 0 || chg)
            pending.push_back(r);
        frames[t] = 0; bytes_q[t] = 0; samples[t] = 0; peak[t] = 0; msum[t] = 0;
        last_gen[t] = it.fmt_generation;
        last_act[t] = it.active_flag;
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    task check_result(alm_pkg::result_t g);
        alm_pkg::result_t e;
        if (pending.size() == 0)
        begin
            report("unexpected word", 0, 0);
            return;
        end
        e = pending.pop_front();
        if (g.report_tap != e.report_tap) report("report_tap", g.report_tap, e.report_tap);
        if (g.frame_count != e.frame_count) report("frame_count", g.frame_count, e.frame_count);
        if (g.byte_count != e.byte_count) report("byte_count", g.byte_count, e.byte_count);
        if (g.sampled_count != e.sampled_count)
            report("sampled_count", g.sampled_count, e.sampled_count);
        if (g.peak_level != e.peak_level) report("peak_level", g.peak_level, e.peak_level);
        if (g.mean_level != e.mean_level) report("mean_level", g.mean_level, e.mean_level);
        if (g.peak_per_mille != e.peak_per_mille)
            report("peak_per_mille", g.peak_per_mille, e.peak_per_mille);
        if (g.mean_per_mille != e.mean_per_mille)
            report("mean_per_mille", g.mean_per_mille, e.mean_per_mille);
        if (g.status_changed != e.status_changed)
            report("status_changed", g.status_changed, e.status_changed);
    endtask
endclass

module audio_level_meter_two_tap_core_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import alm_pkg::*;

    logic clk, rst_n;
    logic decimation_we;
    logic [7:0] decimation_wdata;
    logic in_valid, in_ready;
    logic action, tap, wide_format, frame_start, active_flag;
    logic signed [31:0] sample;
    logic [15:0] frame_bytes;
    logic [31:0] fmt_generation;
    logic [7:0] qval;
    logic out_valid, out_ready;
    result_t res;
    level_scoreboard sb;
    int cycles;
    int hold_off;
    logic [31:0] gen_now;
    logic act_now;

    audio_level_meter_two_tap_core dut (
        .clk(clk), .rst_n(rst_n),
        .decimation_we(decimation_we), .decimation_wdata(decimation_wdata),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .tap(tap), .sample(sample), .wide_format(wide_format),
        .frame_start(frame_start), .frame_bytes(frame_bytes),
        .fmt_generation(fmt_generation), .active_flag(active_flag),
        .qval(qval),
        .out_valid(out_valid), .out_ready(out_ready),
        .report_tap(res.report_tap), .frame_count(res.frame_count),
        .byte_count(res.byte_count), .sampled_count(res.sampled_count),
        .peak_level(res.peak_level), .mean_level(res.mean_level),
        .peak_per_mille(res.peak_per_mille), .mean_per_mille(res.mean_per_mille),
        .status_changed(res.status_changed)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        sb = new();
        sb.clear_state();
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial
    begin
        int w;
        out_ready = 0;
        @(posedge rst_n);
        forever
        begin
            if (hold_off > 0)
            begin
                out_ready <= 0;
                repeat (hold_off) @(posedge clk);
                hold_off = 0;
            end
            w = $urandom_range(0, 6);
            if ($urandom_range(0, 3) == 0) w = 0;
            if (w > 0)
            begin
                out_ready <= 0;
                repeat (w) @(posedge clk);
            end
            out_ready <= 1;
            @(posedge clk);
            while (!(out_valid && out_ready))
                @(posedge clk);
            sb.check_result(res);
        end
    end

    task send_word(logic a, logic t, logic [31:0] s, logic wf, logic fst,
                   logic [15:0] fb, logic [31:0] g, logic sa, logic [7:0] q);
        int w;
        item_t it;
        w = $urandom_range(0, 6);
        if ($urandom_range(0, 3) == 0) w = 0;
        if (w > 0)
        begin
            in_valid <= 0;
            repeat (w) @(posedge clk);
        end
        in_valid <= 1; action <= a; tap <= t; sample <= s; wide_format <= wf;
        frame_start <= fst; frame_bytes <= fb; fmt_generation <= g;
        active_flag <= sa; qval <= q;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        it = '{a, t, s, wf, fst, fb, g, sa, q};
        sb.note_input(it);
    endtask

    task rand_sample(logic t);
        logic [31:0] s;
        case ($urandom_range(0, 4))
            0: s = 32'h8000_0000;
            1: s = 32'h7fff_ffff;
            2: s = {16'h0, 16'h8000};
            default: s = $urandom;
        endcase
        send_word(ACT_SAMPLE, t, s, 1'($urandom_range(0, 1)), $urandom_range(0, 5) == 0,
                  16'($urandom), $urandom, 1'($urandom_range(0, 1)), 8'($urandom));
    endtask

    task rand_report(logic t);
        if ($urandom_range(0, 2) == 0) gen_now = $urandom;
        if ($urandom_range(0, 3) == 0) act_now = ~act_now;
        send_word(ACT_REPORT, t, $urandom, 1'($urandom_range(0, 1)),
                  1'($urandom_range(0, 1)), 16'($urandom), gen_now, act_now,
                  $urandom_range(0, 3) == 0 ? 8'($urandom) : 8'($urandom_range(0, 32)));
    endtask

    task drain();
        in_valid <= 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task set_decimation(logic [7:0] d);
        decimation_we <= 1;
        decimation_wdata <= d;
        @(posedge clk);
        decimation_we <= 0;
        sb.decim = d;
    endtask

    initial
    begin
        logic [7:0] decims [5];
        int n;
        decims = '{8'd1, 8'd255, 8'd3, 8'd0, 8'd2};
        hold_off = 0; gen_now = 0; act_now = 0;
        rst_n = 0; decimation_we = 0; decimation_wdata = 0; in_valid = 0;
        action = 0; tap = 0; sample = 0; wide_format = 0; frame_start = 0;
        frame_bytes = 0; fmt_generation = 0; active_flag = 0; qval = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // directed: extremes, zero-length frame, no-change report, saturation
        send_word(ACT_REPORT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_word(ACT_SAMPLE, 0, 32'h8000_0000, 1, 1, 16'd0, 0, 0, 0);
        send_word(ACT_SAMPLE, 0, 32'h7fff_ffff, 1, 0, 16'd1, 0, 0, 0);
        send_word(ACT_SAMPLE, 0, 32'h1234_8000, 0, 0, 16'd1, 0, 0, 0);
        send_word(ACT_SAMPLE, 0, 32'h0000_7fff, 0, 1, 16'hffff, 0, 0, 0);
        send_word(ACT_REPORT, 0, 0, 0, 0, 0, 32'hffff_ffff, 1, 8'd0);
        send_word(ACT_SAMPLE, 1, 32'hffff_ffff, 1, 0, 16'd5, 0, 0, 0);
        send_word(ACT_REPORT, 1, 0, 0, 0, 0, 0, 0, 8'd1);
        send_word(ACT_REPORT, 1, 0, 0, 0, 0, 0, 1, 8'd31);
        send_word(ACT_SAMPLE, 1, 32'hdead_beef, 1, 1, 16'd100, 0, 0, 0);
        send_word(ACT_REPORT, 1, 0, 0, 0, 0, 0, 1, 8'd30);
        send_word(ACT_SAMPLE, 0, 32'h0000_0001, 0, 1, 16'd7, 0, 0, 0);
        send_word(ACT_REPORT, 0, 0, 0, 0, 0, 32'hffff_ffff, 1, 8'd255);
        send_word(ACT_REPORT, 0, 0, 0, 0, 0, 32'hffff_ffff, 1, 8'd16);
        drain();

        // long receiver hold-off while the sender keeps pushing
        hold_off = 400;
        for (int i = 0; i < 30; i++)
        begin
            rand_sample(i[0]);
            if (i % 3 == 0) send_word(ACT_REPORT, i[1], 0, 0, 0, 0, $urandom, 1, 8'd0);
        end
        drain();

        for (int p = 0; p < 5; p++)
        begin
            set_decimation(decims[p]);
            // lower decimation after building phase is checked by the next pass
            n = 0;
            while (n < 340)
            begin
                logic t;
                t = 1'($urandom_range(0, 1));
                send_word(ACT_SAMPLE, t, $urandom, 1'($urandom_range(0, 1)), 1,
                          16'($urandom), 0, 0, 0);
                n++;
                repeat ($urandom_range(0, 12))
                begin
                    rand_sample(t);
                    n++;
                end
                if ($urandom_range(0, 2) == 0)
                begin
                    rand_report(t);
                    n++;
                end
            end
            rand_report(0);
            rand_report(1);
            drain();
        end

        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end
endmodule

`default_nettype wire
